[src/link_health_hysteresis_table_macros.svh]
// Assertion helpers for the block's checker.
`ifndef LINK_HEALTH_HYSTERESIS_TABLE_MACROS_SVH
`define LINK_HEALTH_HYSTERESIS_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LHHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lhht check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LHHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lhht check failed");

`endif

[src/lhht_pkg.sv]
package lhht_pkg;

  // Field widths
  localparam int OP_W       = 3;
  localparam int SLOT_IN_W  = 3;
  localparam int MISS_W     = 4;
  localparam int MASK_W     = 8;
  localparam int THR_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [MISS_W-1:0] MISS_MAX  = 4'd15;
  localparam logic [THR_W-1:0]  THR_RESET = 4'd2;

  // Event codes
  localparam logic [OP_W-1:0] OP_PROBE     = 3'd0;
  localparam logic [OP_W-1:0] OP_FORCE     = 3'd1;
  localparam logic [OP_W-1:0] OP_VERIFY    = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
  localparam logic [OP_W-1:0] OP_TAKE_NEXT = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SCAN,
    ST_SEND
  } state_t;

endpackage

[src/lhht_if.sv]
// Event channel
interface lhht_in_if;
  logic                           valid;
  logic                           ready;
  logic [lhht_pkg::OP_W-1:0]      op;
  logic [lhht_pkg::SLOT_IN_W-1:0] slot;
  logic                           reported_online;
  logic                           forced_known;

  modport source (output valid, op, slot, reported_online, forced_known, input ready);
  modport sink   (input valid, op, slot, reported_online, forced_known, output ready);
endinterface

// Result channel
interface lhht_out_if;
  logic                           valid;
  logic                           ready;
  logic                           entry_known;
  logic                           entry_online;
  logic                           changed;
  logic [lhht_pkg::SLOT_IN_W-1:0] next_slot;
  logic                           none_configured;

  modport source (output valid, entry_known, entry_online, changed, next_slot,
                  none_configured, input ready);
  modport sink   (input valid, entry_known, entry_online, changed, next_slot,
                  none_configured, output ready);
endinterface

// Register write channel
interface lhht_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lhht_pkg::CFG_IDX_W-1:0]  index;
  logic [lhht_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/link_health_hysteresis_table.sv]
// Link health table: one entry per monitored endpoint slot, each with a known
// flag, an online flag and a saturating miss counter.
// Channels: in_ch carries one event per beat (op, slot, reported_online,
// forced_known); out_ch returns exactly one result beat per event;
// cfg_ch writes configured_mask (index 0) and failure_threshold (index 1)
// and is always ready. Write registers only while the block is idle.
// Steps: probe, force, verifying and clear events go from acceptance to result
// valid through table read, update and result load. Take-next walks the
// slots one per cycle through a single pointer/mask-test step, stopping at
// the first configured slot, or after trying all SLOTS slots when none is.
// Throughput: one event at a time; in_ch.ready is high only while the
// sequencer is idle, so the block takes no new event until the last result
// has been handed to the output register.
// Reset (synchronous, rst_n low) clears all flags, the scan pointer, the mask
// and sets the threshold to 2. Miss counters need no reset: a counter is read
// only on an online entry, and every path to online writes it.
// A stalled receiver holds the result in the output register; the block still
// takes the next event and finishes it, then waits until the register drains.
module link_health_hysteresis_table #(
  parameter int SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  lhht_cfg_if.sink     cfg_ch,
  lhht_in_if.sink      in_ch,
  lhht_out_if.source   out_ch
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int EXT_W  = SLOTS + lhht_pkg::MASK_W;

  lhht_pkg::state_t state_r, state_nxt;

  // Captured event
  logic [lhht_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [lhht_pkg::SLOT_IN_W-1:0] slot_r, slot_nxt;
  logic                           ro_r, ro_nxt;
  logic                           fk_r, fk_nxt;

  // Registers
  logic [lhht_pkg::MASK_W-1:0] mask_r;
  logic [lhht_pkg::THR_W-1:0]  thr_r;

  // Table state
  logic [SLOTS-1:0]  known_r, known_nxt;
  logic [SLOTS-1:0]  online_r, online_nxt;
  logic [SLOT_W-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;

  logic [lhht_pkg::MISS_W-1:0] miss_mem [SLOTS];
  logic [lhht_pkg::MISS_W-1:0] miss_rd_r;
  logic                        miss_we;
  logic [lhht_pkg::MISS_W-1:0] miss_wd;

  // Finished result waiting for the output register
  logic                           res_known_r, res_known_nxt;
  logic                           res_online_r, res_online_nxt;
  logic                           res_chg_r, res_chg_nxt;
  logic [lhht_pkg::SLOT_IN_W-1:0] res_next_r, res_next_nxt;
  logic                           res_none_r, res_none_nxt;

  // Output register
  logic                           out_vld_r, out_vld_nxt;
  logic                           out_known_r, out_online_r, out_chg_r, out_none_r;
  logic [lhht_pkg::SLOT_IN_W-1:0] out_next_r;
  logic                           out_load;

  logic [SLOT_W-1:0]           slot_idx;
  logic                        slot_ok;
  logic [SLOTS-1:0]            cfg_vec;
  logic [EXT_W-1:0]            mask_ext;
  logic [SLOT_W-1:0]           rd_idx;
  logic                        cur_known, cur_online;
  logic [SLOT_W-1:0]           ptr_inc;
  logic [lhht_pkg::MISS_W-1:0] miss_inc;
  logic                        miss_hit;

  // Decode slot and configured map
  assign slot_idx = SLOT_W'(slot_r);
  assign slot_ok  = 32'(slot_r) < SLOTS;
  assign mask_ext = EXT_W'(mask_r);
  assign cfg_vec  = mask_ext[SLOTS-1:0];

  // Single table read port: scan pointer while scanning, else the event slot
  assign rd_idx     = (state_r == lhht_pkg::ST_SCAN) ? scan_ptr_r : slot_idx;
  assign cur_known  = known_r[rd_idx];
  assign cur_online = online_r[rd_idx];

  // Shared step unit: pointer advance and miss count/threshold compare
  assign ptr_inc  = (scan_ptr_r == SLOT_W'(SLOTS - 1)) ? '0 : scan_ptr_r + 1'b1;
  assign miss_inc = (miss_rd_r != lhht_pkg::MISS_MAX) ? miss_rd_r + 1'b1 : miss_rd_r;
  assign miss_hit = miss_inc >= thr_r;

  assign in_ch.ready  = (state_r == lhht_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Sequencer: next state and table updates
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    ro_nxt         = ro_r;
    fk_nxt         = fk_r;
    known_nxt      = known_r;
    online_nxt     = online_r;
    scan_ptr_nxt   = scan_ptr_r;
    scan_cnt_nxt   = scan_cnt_r;
    res_known_nxt  = res_known_r;
    res_online_nxt = res_online_r;
    res_chg_nxt    = res_chg_r;
    res_next_nxt   = res_next_r;
    res_none_nxt   = res_none_r;
    miss_we        = 1'b0;
    miss_wd        = '0;
    out_load       = 1'b0;

    case (state_r)
      lhht_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt       = in_ch.op;
          slot_nxt     = in_ch.slot;
          ro_nxt       = in_ch.reported_online;
          fk_nxt       = in_ch.forced_known;
          scan_cnt_nxt = '0;
          state_nxt    = (in_ch.op == lhht_pkg::OP_TAKE_NEXT) ?
                         lhht_pkg::ST_SCAN : lhht_pkg::ST_READ;
        end
      end

      // Wait for the miss counter read
      lhht_pkg::ST_READ: begin
        state_nxt = lhht_pkg::ST_EXEC;
      end

      // Apply the event to the addressed entry
      lhht_pkg::ST_EXEC: begin
        res_chg_nxt  = 1'b0;
        res_next_nxt = '0;
        res_none_nxt = 1'b0;
        state_nxt    = lhht_pkg::ST_SEND;
        if (!slot_ok) begin
          res_known_nxt  = 1'b0;
          res_online_nxt = 1'b0;
        end else begin
          res_known_nxt  = cur_known;
          res_online_nxt = cur_online;
          case (op_r)
            lhht_pkg::OP_PROBE: begin
              if (ro_r) begin
                res_chg_nxt    = !cur_known || !cur_online;
                res_known_nxt  = 1'b1;
                res_online_nxt = 1'b1;
                miss_we        = 1'b1;
                miss_wd        = '0;
              end else if (!cur_known) begin
                res_known_nxt  = 1'b1;
                res_online_nxt = 1'b0;
                res_chg_nxt    = 1'b1;
                miss_we        = 1'b1;
                miss_wd        = thr_r;
              end else if (cur_online) begin
                miss_we = 1'b1;
                miss_wd = miss_inc;
                if (miss_hit) begin
                  res_online_nxt = 1'b0;
                  res_chg_nxt    = 1'b1;
                end
              end
            end
            lhht_pkg::OP_FORCE: begin
              res_chg_nxt    = (cur_known != fk_r) || (fk_r && (cur_online != ro_r));
              res_known_nxt  = fk_r;
              res_online_nxt = ro_r;
              miss_we        = 1'b1;
              miss_wd        = '0;
            end
            lhht_pkg::OP_VERIFY, lhht_pkg::OP_CLEAR: begin
              res_chg_nxt    = cur_known || cur_online;
              res_known_nxt  = 1'b0;
              res_online_nxt = 1'b0;
              miss_we        = 1'b1;
              miss_wd        = '0;
            end
            default: begin
              res_chg_nxt = 1'b0;
            end
          endcase
          known_nxt[slot_idx]  = res_known_nxt;
          online_nxt[slot_idx] = res_online_nxt;
        end
      end

      // Test one slot per cycle, advance the pointer
      lhht_pkg::ST_SCAN: begin
        scan_ptr_nxt = ptr_inc;
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        res_chg_nxt  = 1'b0;
        if (cfg_vec[scan_ptr_r]) begin
          res_known_nxt  = cur_known;
          res_online_nxt = cur_online;
          res_next_nxt   = lhht_pkg::SLOT_IN_W'(scan_ptr_r);
          res_none_nxt   = 1'b0;
          state_nxt      = lhht_pkg::ST_SEND;
        end else if (scan_cnt_r == CNT_W'(SLOTS - 1)) begin
          res_known_nxt  = 1'b0;
          res_online_nxt = 1'b0;
          res_next_nxt   = '0;
          res_none_nxt   = 1'b1;
          state_nxt      = lhht_pkg::ST_SEND;
        end
      end

      // Hand the result to the output register once it is free
      lhht_pkg::ST_SEND: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = lhht_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lhht_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lhht_pkg::ST_IDLE;
      known_r    <= '0;
      online_r   <= '0;
      scan_ptr_r <= '0;
      scan_cnt_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      known_r    <= known_nxt;
      online_r   <= online_nxt;
      scan_ptr_r <= scan_ptr_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      thr_r  <= lhht_pkg::THR_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        lhht_pkg::REG_MASK:   mask_r <= cfg_ch.data[lhht_pkg::MASK_W-1:0];
        lhht_pkg::REG_THRESH: thr_r  <= cfg_ch.data[lhht_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    ro_r         <= ro_nxt;
    fk_r         <= fk_nxt;
    res_known_r  <= res_known_nxt;
    res_online_r <= res_online_nxt;
    res_chg_r    <= res_chg_nxt;
    res_next_r   <= res_next_nxt;
    res_none_r   <= res_none_nxt;
    if (out_load) begin
      out_known_r  <= res_known_r;
      out_online_r <= res_online_r;
      out_chg_r    <= res_chg_r;
      out_next_r   <= res_next_r;
      out_none_r   <= res_none_r;
    end
  end

  // Miss counter memory: registered read at the event slot
  always_ff @(posedge clk) begin
    miss_rd_r <= miss_mem[slot_idx];
    if (miss_we) begin
      miss_mem[slot_idx] <= miss_wd;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.entry_known     = out_known_r;
  assign out_ch.entry_online    = out_online_r;
  assign out_ch.changed         = out_chg_r;
  assign out_ch.next_slot       = out_next_r;
  assign out_ch.none_configured = out_none_r;

endmodule

[src/lhht_chk.sv]
`include "link_health_hysteresis_table_macros.svh"

module lhht_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_known,
  input logic                           out_online,
  input logic                           out_changed,
  input logic [lhht_pkg::SLOT_IN_W-1:0] out_next_slot,
  input logic                           out_none
);

  // Stalled result beat holds
  `LHHT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_known) && $stable(out_online) && $stable(out_changed) && $stable(out_next_slot) && $stable(out_none))

  // Busy after taking an event
  `LHHT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // Empty scan reports nothing else
  `LHHT_ASSERT_IMP(a_none_is_zero, out_valid && out_none, !out_known && !out_online && !out_changed && (out_next_slot == '0))

  // A changed entry never comes from a scan
  `LHHT_ASSERT_IMP(a_changed_no_scan, out_valid && out_changed, (out_next_slot == '0) && !out_none)

endmodule

bind link_health_hysteresis_table lhht_chk u_lhht_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_known     (out_ch.entry_known),
  .out_online    (out_ch.entry_online),
  .out_changed   (out_ch.changed),
  .out_next_slot (out_ch.next_slot),
  .out_none      (out_ch.none_configured)
);
